@@ hw/rtl/vehicle_fault_supervisor_defines.svh @@
// assertion macros for the fault supervisor
`ifndef VEHICLE_FAULT_SUPERVISOR_DEFINES_SVH
`define VEHICLE_FAULT_SUPERVISOR_DEFINES_SVH

`ifndef SYNTHESIS
`define VFS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define VFS_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define VFS_ASSERT(label, prop, msg)
`define VFS_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

@@ hw/rtl/vfs_pkg.sv @@
package vfs_pkg;

	localparam logic [1:0] CMD_TICK    = 2'd0;
	localparam logic [1:0] CMD_ENABLE  = 2'd1;
	localparam logic [1:0] CMD_DISABLE = 2'd2;

	localparam logic [1:0] MODE_MANUAL    = 2'd0;
	localparam logic [1:0] MODE_AUTO      = 2'd1;
	localparam logic [1:0] MODE_EMERGENCY = 2'd2;

	localparam logic [1:0] ERR_NONE    = 2'd0;
	localparam logic [1:0] ERR_CHASSIS = 2'd1;
	localparam logic [1:0] ERR_MANUAL  = 2'd2;

	localparam logic [7:0] LIMIT_RESET = 8'd10;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [5:0]  steer_faults;
		logic [1:0]  motor_faults;
		logic [10:0] brake_faults;
		logic [1:0]  link_faults;
		logic [1:0]  fault_level;
		logic        emergency_stop;
		logic        battery_offline;
		logic        remote_offline;
		logic        remote_closed;
	} req_item_t;

	typedef struct packed {
		logic [1:0]  op_mode;
		logic [1:0]  fault_code;
		logic [25:0] fault_mask;
		logic        entered_emergency;
		logic        serious_fault;
		logic        aux_warning;
	} rsp_item_t;

	typedef struct packed {
		logic valid;
		logic take;
	} stage_ctl_t;

endpackage

@@ hw/rtl/vfs_in_stage.sv @@
module vfs_in_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  vfs_pkg::req_item_t  req,
	input  logic                take,
	output vfs_pkg::stage_ctl_t ctl,
	output vfs_pkg::req_item_t  item_s1
);
	import vfs_pkg::*;

	logic valid_s1;

	assign req_ready = !valid_s1 || take;
	assign ctl.valid = valid_s1;
	assign ctl.take  = valid_s1 && take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			item_s1 <= req;
		end
	end

endmodule

@@ hw/rtl/vfs_supervisor.sv @@
module vfs_supervisor (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [7:0]          cfg_wdata,
	input  vfs_pkg::stage_ctl_t ctl,
	input  vfs_pkg::req_item_t  item_s1,
	output vfs_pkg::rsp_item_t  result
);
	import vfs_pkg::*;

	logic [7:0]  fail_limit_q;
	logic [1:0]  mode_q;
	logic [1:0]  error_q;
	logic [25:0] mask_q;
	logic [7:0]  motor_cnt_q;
	logic [7:0]  steer_cnt_q;
	logic [7:0]  chassis_cnt_q;

	logic [1:0]  mode_d;
	logic [1:0]  error_d;
	logic [25:0] mask_d;
	logic [7:0]  motor_cnt_d;
	logic [7:0]  steer_cnt_d;
	logic [7:0]  chassis_cnt_d;
	logic [8:0]  motor_b;
	logic [8:0]  steer_b;
	logic [8:0]  chassis_b;
	logic        level;
	logic        serious;
	logic        aux;
	logic        in_auto;
	logic        trip;
	logic        entered;

	// returns {trip, next count}
	function automatic logic [8:0] bump(input logic [7:0] cnt, input logic failing,
			input logic [7:0] limit);
		logic [7:0] nxt;
		nxt = cnt;
		if (!failing) begin
			return 9'd0;
		end
		if (cnt < limit) begin
			nxt = cnt + 8'd1;
		end
		return {(nxt >= limit), nxt};
	endfunction

	assign level   = |item_s1.fault_level;
	assign serious = |{item_s1.steer_faults, item_s1.motor_faults, item_s1.brake_faults,
		item_s1.link_faults, level, item_s1.emergency_stop};
	assign aux     = item_s1.battery_offline | item_s1.remote_offline | item_s1.remote_closed;
	assign in_auto = (mode_q == MODE_AUTO);

	assign motor_b   = bump(motor_cnt_q, in_auto && (|item_s1.motor_faults), fail_limit_q);
	assign steer_b   = bump(steer_cnt_q, in_auto && (|item_s1.steer_faults), fail_limit_q);
	assign chassis_b = bump(chassis_cnt_q, serious, fail_limit_q);

	always_comb begin
		mode_d        = mode_q;
		error_d       = error_q;
		mask_d        = mask_q;
		motor_cnt_d   = motor_cnt_q;
		steer_cnt_d   = steer_cnt_q;
		chassis_cnt_d = chassis_cnt_q;
		trip          = 1'b0;
		entered       = 1'b0;
		unique case (item_s1.cmd)
			CMD_TICK: begin
				mask_d = {item_s1.remote_closed, item_s1.remote_offline,
					item_s1.battery_offline, item_s1.emergency_stop, level,
					item_s1.link_faults, item_s1.brake_faults, item_s1.motor_faults,
					item_s1.steer_faults};
				motor_cnt_d   = motor_b[7:0];
				steer_cnt_d   = steer_b[7:0];
				chassis_cnt_d = chassis_b[7:0];
				if (motor_b[8] || steer_b[8]) begin
					error_d = ERR_MANUAL;
				end
				if (chassis_b[8]) begin
					error_d = ERR_CHASSIS;
				end
				trip = motor_b[8] | steer_b[8] | chassis_b[8];
				if (trip && mode_q != MODE_EMERGENCY) begin
					mode_d  = MODE_EMERGENCY;
					entered = 1'b1;
					if (error_d == ERR_NONE) begin
						error_d = ERR_CHASSIS;
					end
				end
			end
			CMD_ENABLE: begin
				mode_d = MODE_AUTO;
			end
			CMD_DISABLE: begin
				mode_d  = MODE_MANUAL;
				error_d = ERR_NONE;
			end
			default: begin
			end
		endcase
	end

	assign result.op_mode           = mode_d;
	assign result.fault_code        = error_d;
	assign result.fault_mask        = mask_d;
	assign result.entered_emergency = entered;
	assign result.serious_fault     = (item_s1.cmd == CMD_TICK) && serious;
	assign result.aux_warning       = (item_s1.cmd == CMD_TICK) && aux;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fail_limit_q  <= LIMIT_RESET;
			mode_q        <= MODE_MANUAL;
			error_q       <= ERR_NONE;
			mask_q        <= '0;
			motor_cnt_q   <= '0;
			steer_cnt_q   <= '0;
			chassis_cnt_q <= '0;
		end else begin
			if (cfg_we) begin
				fail_limit_q <= cfg_wdata;
			end
			if (ctl.take) begin
				mode_q        <= mode_d;
				error_q       <= error_d;
				mask_q        <= mask_d;
				motor_cnt_q   <= motor_cnt_d;
				steer_cnt_q   <= steer_cnt_d;
				chassis_cnt_q <= chassis_cnt_d;
			end
		end
	end

endmodule

@@ hw/rtl/vehicle_fault_supervisor.sv @@
// channel | direction | handshake               | payload
// req     | in        | req_valid / req_ready   | req_item_t
// rsp     | out       | rsp_valid / rsp_ready   | rsp_item_t
// cfg     | in        | cfg_we, no wait         | cfg_wdata (fail_limit)
//
// one item per cycle unless rsp stalls; rsp valid after input and result registers
// the input register feeds the fault logic, which writes the result register
// and the mode, error, mask and counter registers on the same edge
// a full result register that is not taken holds the input register, then req_ready
// reset clears all state, sets the limit to 10 and empties both registers
`include "vehicle_fault_supervisor_defines.svh"

module vehicle_fault_supervisor (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  vfs_pkg::req_item_t req,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output vfs_pkg::rsp_item_t rsp,
	input  logic               cfg_we,
	input  logic [7:0]         cfg_wdata
);
	import vfs_pkg::*;

	stage_ctl_t ctl;
	req_item_t  item_s1;
	rsp_item_t  result;
	logic       take;
	logic       rsp_valid_q;
	rsp_item_t  rsp_q;

	assign take = !rsp_valid_q || rsp_ready;

	vfs_in_stage u_in_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.take      (take),
		.ctl       (ctl),
		.item_s1   (item_s1)
	);

	vfs_supervisor u_supervisor (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.ctl       (ctl),
		.item_s1   (item_s1),
		.result    (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (take) begin
			rsp_valid_q <= ctl.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.take) begin
			rsp_q <= result;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`VFS_ASSERT(a_entered_mode, rsp_valid && rsp.entered_emergency |-> rsp.op_mode == MODE_EMERGENCY && rsp.fault_code != ERR_NONE, "entered emergency without emergency mode and error")
	`VFS_ASSERT(a_serious_mask, rsp_valid && rsp.serious_fault |-> (|rsp.fault_mask[22:0]), "serious fault with clean mask")
	`VFS_ASSERT(a_stall_cause, !req_ready |-> ctl.valid && rsp_valid && !rsp_ready, "input stalled without a full pipeline")
	`VFS_ASSERT_ALWAYS(a_reset_empty, !arst_n |-> !rsp_valid && !ctl.valid, "registers not empty in reset")

endmodule
